[hw/rtl/fgsm_pkg.sv]
package fgsm_pkg;

  // Pixel commands
  typedef enum logic [1:0] {
    CMD_GAMMA_DEC = 2'd0,
    CMD_GAMMA_ENC = 2'd1,
    CMD_FILM_DEC  = 2'd2,
    CMD_FILM_ENC  = 2'd3
  } cmd_t;

  // Saturation is Q1.16, 1.0 is 65536, so 17 bits
  localparam int SAT_W = 17;
  localparam logic [SAT_W-1:0] SAT_ONE = 17'h10000;

  // Reciprocal constants for 21-bit dividends: floor(x/d) = (x*K) >> S
  localparam int RX_W = 21;
  localparam int RK_W = 22;
  localparam logic [RK_W-1:0] RECIP_10 = 22'd3355444;
  localparam logic [RK_W-1:0] RECIP_29 = 22'd2314099;
  localparam logic [RK_W-1:0] RECIP_9  = 22'd3728271;
  localparam int SHIFT_10 = 25;
  localparam int SHIFT_29 = 26;
  localparam int SHIFT_9  = 25;

endpackage

[hw/rtl/filmic_gamma_saturation_map_top.sv]
// Channel | handshake               | payload
// in      | in_valid / in_stall     | command, in_red, in_green, in_blue
// out     | out_valid / out_stall   | out_red, out_green, out_blue
//
// One pixel per clock while no stalled result holds the pipeline. The stages are
// input/ROM, max-min, the saturation divider (load plus 17 quotient-bit stages),
// three remap, dividend, the channel rebuild dividers (load plus CHANNEL_BITS+1
// stages), select and output stages.
// rst is synchronous and clears all valid bits; payload is not reset.
// A stalled result holds the whole pipeline; in_stall follows from it.
module filmic_gamma_saturation_map_top #(
  parameter int CHANNEL_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              command,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHANNEL_BITS-1:0] out_red,
  output logic [CHANNEL_BITS-1:0] out_green,
  output logic [CHANNEL_BITS-1:0] out_blue
);

  localparam int CB  = CHANNEL_BITS;
  localparam int SA  = fgsm_pkg::SAT_W;
  localparam int MSW = 2 + 1 + 4 * CB;   // cmd, bypass, v, three channels
  localparam int RSW = 2 + 1 + 2 * CB;   // cmd, bypass, v, red

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: input register and decode lookup
  logic          v1;
  fgsm_pkg::cmd_t cmd1;
  logic [CB-1:0] raw1 [3];
  logic [CB-1:0] dec1 [3];
  logic [CB-1:0] in_ch [3];
  assign in_ch[0] = in_red;
  assign in_ch[1] = in_green;
  assign in_ch[2] = in_blue;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= fgsm_pkg::cmd_t'(command);
      raw1 <= in_ch;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dec
    fgsm_gamma_rom #(.CB(CB), .ENCODE(1'b0)) u_dec (
      .clk(clk), .en(en), .addr(in_ch[i]), .data(dec1[i])
    );
  end

  // stage 2: pick decoded or raw, find max and min
  logic [CB-1:0] c_sel [3];
  logic [CB-1:0] mx, mn;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_sel[i] = (cmd1 == fgsm_pkg::CMD_GAMMA_DEC || cmd1 == fgsm_pkg::CMD_FILM_DEC)
                 ? dec1[i] : raw1[i];
    end
    mx = c_sel[0];
    mn = c_sel[0];
    for (int i = 1; i < 3; i++) begin
      if (c_sel[i] > mx) mx = c_sel[i];
      if (c_sel[i] < mn) mn = c_sel[i];
    end
  end

  logic          v2;
  logic [MSW-1:0] side2;
  logic [CB+15:0] num2;
  logic [CB-1:0]  den2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  // gray pixels and plain gamma skip the saturation path
  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= {cmd1, (!cmd1[1]) || (mx == mn), mx, c_sel[0], c_sel[1], c_sel[2]};
      num2  <= {mx - mn, 16'h0000};
      den2  <= mx;
    end
  end

  // saturation s = (V - min) * 2^16 / V
  logic           vd;
  logic [SA-1:0]  s_d;
  logic           ovf_d;
  logic [MSW-1:0] side_d;
  fgsm_div #(.NW(CB + 16), .DW(CB), .QW(SA), .SW(MSW)) u_sat_div (
    .clk(clk), .rst(rst), .en(en), .in_vld(v2), .num(num2), .den(den2),
    .side_in(side2), .out_vld(vd), .quo(s_d), .ovf(ovf_d), .side_out(side_d)
  );

  // remap
  logic           vr;
  logic [SA-1:0]  s_r, sn_r;
  logic [MSW-1:0] side_r;
  fgsm_sat_remap #(.SW(MSW)) u_remap (
    .clk(clk), .rst(rst), .en(en), .in_vld(vd && !ovf_d), .s_in(s_d),
    .inverse(side_d[MSW-1 -: 2] == fgsm_pkg::CMD_FILM_DEC), .side_in(side_d),
    .out_vld(vr), .s_out(s_r), .sn(sn_r), .side_out(side_r)
  );
  // ovf only occurs on black pixels, which are bypassed; keep the item
  logic vr_all;
  logic vd_ovf;
  always_ff @(posedge clk) begin
    if (rst) vd_ovf <= 1'b0;
    else if (en) vd_ovf <= vd && ovf_d;
  end
  logic [1:0] ovf_line;
  always_ff @(posedge clk) begin
    if (rst) ovf_line <= '0;
    else if (en) ovf_line <= {ovf_line[0], vd_ovf};
  end
  assign vr_all = vr || ovf_line[1];

  // stage M: rebuild dividends (V - c) * s' + s/2
  logic [CB-1:0] vm_r;
  logic [CB-1:0] cr [3];
  assign vm_r  = side_r[3*CB +: CB];
  assign cr[0] = side_r[2*CB +: CB];
  assign cr[1] = side_r[CB +: CB];
  assign cr[2] = side_r[0 +: CB];

  logic           vm;
  logic [CB+16:0] numm [3];
  logic [SA-1:0]  sm;
  logic [RSW-1:0] sidem_r;
  logic [CB-1:0]  sidem_g, sidem_b;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (en) vm <= vr_all;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        numm[i] <= (CB+17)'((CB+17)'(vm_r - cr[i]) * (CB+17)'(sn_r))
                   + (CB+17)'(s_r >> 1);
      end
      sm      <= s_r;
      sidem_r <= {side_r[MSW-1 -: 3 + CB], cr[0]};
      sidem_g <= cr[1];
      sidem_b <= cr[2];
    end
  end

  // per-channel delta = dividend / s
  logic           vq;
  logic [CB:0]    dq [3];
  logic           oq [3];
  logic [RSW-1:0] sideq_r;
  logic [CB-1:0]  sideq_g, sideq_b;
  logic           vq_g, vq_b;

  fgsm_div #(.NW(CB + 17), .DW(SA), .QW(CB + 1), .SW(RSW)) u_div_r (
    .clk(clk), .rst(rst), .en(en), .in_vld(vm), .num(numm[0]), .den(sm),
    .side_in(sidem_r), .out_vld(vq), .quo(dq[0]), .ovf(oq[0]), .side_out(sideq_r)
  );
  fgsm_div #(.NW(CB + 17), .DW(SA), .QW(CB + 1), .SW(CB)) u_div_g (
    .clk(clk), .rst(rst), .en(en), .in_vld(vm), .num(numm[1]), .den(sm),
    .side_in(sidem_g), .out_vld(vq_g), .quo(dq[1]), .ovf(oq[1]), .side_out(sideq_g)
  );
  fgsm_div #(.NW(CB + 17), .DW(SA), .QW(CB + 1), .SW(CB)) u_div_b (
    .clk(clk), .rst(rst), .en(en), .in_vld(vm), .num(numm[2]), .den(sm),
    .side_in(sidem_b), .out_vld(vq_b), .quo(dq[2]), .ovf(oq[2]), .side_out(sideq_b)
  );

  // stage F: c' = V - delta, clamped at zero, or the channel untouched
  fgsm_pkg::cmd_t cmdq;
  logic           byq;
  logic [CB-1:0]  vvq;
  logic [CB-1:0]  cq [3];
  assign cmdq  = fgsm_pkg::cmd_t'(sideq_r[RSW-1 -: 2]);
  assign byq   = sideq_r[RSW-3];
  assign vvq   = sideq_r[CB +: CB];
  assign cq[0] = sideq_r[0 +: CB];
  assign cq[1] = sideq_g;
  assign cq[2] = sideq_b;

  logic [CB-1:0] cf_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (byq) cf_c[i] = cq[i];
      else if (oq[i] || dq[i] >= {1'b0, vvq}) cf_c[i] = '0;
      else cf_c[i] = vvq - dq[i][CB-1:0];
    end
  end

  logic          vf;
  fgsm_pkg::cmd_t cmdf;
  logic [CB-1:0] cf [3];
  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= vq && vq_g && vq_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmdf <= cmdq;
      cf   <= cf_c;
    end
  end

  // output stage: encode lookup or pass
  logic          vo;
  logic          use_enc;
  logic [CB-1:0] pass_o [3];
  logic [CB-1:0] enc_o  [3];
  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (en) vo <= vf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      use_enc <= (cmdf == fgsm_pkg::CMD_GAMMA_ENC) || (cmdf == fgsm_pkg::CMD_FILM_ENC);
      pass_o  <= cf;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_enc
    fgsm_gamma_rom #(.CB(CB), .ENCODE(1'b1)) u_enc (
      .clk(clk), .en(en), .addr(cf[i]), .data(enc_o[i])
    );
  end

  assign out_valid = vo;
  assign out_red   = use_enc ? enc_o[0] : pass_o[0];
  assign out_green = use_enc ? enc_o[1] : pass_o[1];
  assign out_blue  = use_enc ? enc_o[2] : pass_o[2];

endmodule

[hw/rtl/fgsm_gamma_rom.sv]
module fgsm_gamma_rom #(
  parameter int CB = 12,
  parameter bit ENCODE = 1'b0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CB-1:0] addr,
  output logic [CB-1:0] data
);

  localparam int  DEPTH = 1 << CB;
  localparam real M_R   = real'((1 << CB) - 1);
  localparam real INV_M = 1.0 / M_R;
  localparam real EXPO  = ENCODE ? (5.0 / 11.0) : (11.0 / 5.0);

  // round(M * (x/M)^g), g = 11/5 for decode, 5/11 for encode
  function automatic int gamma_code(int x);
    real t;
    t = (real'(x) * INV_M) ** EXPO;
    return int'($floor(M_R * t + 0.5));
  endfunction

  logic [CB-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_fill
    assign rom[g] = CB'(gamma_code(g));
  end

  // registered read
  always_ff @(posedge clk) begin
    if (en) data <= rom[addr];
  end

endmodule

[hw/rtl/fgsm_div.sv]
module fgsm_div #(
  parameter int NW = 28,
  parameter int DW = 12,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  // stage 0 loads, stages 1..QW produce one quotient bit each
  logic          vld  [QW+1];
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [DW-1:0] dv   [QW+1];
  logic          of   [QW+1];
  logic [SW-1:0] side [QW+1];

  logic [NW-QW-1:0] head;
  assign head = num[NW-1:QW];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_vld;
  end

  // quotient would not fit when the leading part already reaches den
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DW'(head);
      low[0]  <= num[QW-1:0];
      q[0]    <= '0;
      dv[0]   <= den;
      of[0]   <= ({{DW{1'b0}}, head} >= {{(NW-QW){1'b0}}, den});
      side[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        take;
    assign trial = {rem[k-1], low[k-1][QW-1]};
    assign take  = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (en) vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? DW'(trial - {1'b0, dv[k-1]}) : DW'(trial);
        low[k]  <= {low[k-1][QW-2:0], 1'b0};
        q[k]    <= {q[k-1][QW-2:0], take};
        dv[k]   <= dv[k-1];
        of[k]   <= of[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_vld  = vld[QW];
  assign quo      = q[QW];
  assign ovf      = of[QW];
  assign side_out = side[QW];

endmodule

[hw/rtl/fgsm_sat_remap.sv]
module fgsm_sat_remap #(
  parameter int SW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [fgsm_pkg::SAT_W-1:0] s_in,
  input  logic                      inverse,
  input  logic [SW-1:0]             side_in,
  output logic                      out_vld,
  output logic [fgsm_pkg::SAT_W-1:0] s_out,
  output logic [fgsm_pkg::SAT_W-1:0] sn,
  output logic [SW-1:0]             side_out
);

  localparam int SA = fgsm_pkg::SAT_W;
  localparam int XW = fgsm_pkg::RX_W;
  localparam int KW = fgsm_pkg::RK_W;

  logic          va, vb, vc;
  logic [SA-1:0] sa, sb;
  logic [SW-1:0] sda, sdb;
  logic [XW-1:0] xa;
  logic [KW-1:0] ka;
  logic          sha, shb;
  logic          nga, ngb;
  logic [XW+KW-1:0] prod;

  // piece select and dividend
  logic [31:0] s32, rest;
  logic [XW-1:0] x_c;
  logic [KW-1:0] k_c;
  logic sh_c, ng_c;
  always_comb begin
    s32  = 32'(s_in);
    rest = 32'(fgsm_pkg::SAT_ONE) - s32;
    if (!inverse) begin
      if (20 * s32 > 19 * 32'(fgsm_pkg::SAT_ONE)) begin
        x_c = XW'(rest * 29 + 5);
        k_c = fgsm_pkg::RECIP_10; sh_c = 1'b0; ng_c = 1'b1;
      end else begin
        x_c = XW'(s32 * 9 + 5);
        k_c = fgsm_pkg::RECIP_10; sh_c = 1'b0; ng_c = 1'b0;
      end
    end else begin
      if (200 * s32 > 171 * 32'(fgsm_pkg::SAT_ONE)) begin
        x_c = XW'(rest * 10 + 14);
        k_c = fgsm_pkg::RECIP_29; sh_c = 1'b1; ng_c = 1'b1;
      end else begin
        x_c = XW'(s32 * 10 + 4);
        k_c = fgsm_pkg::RECIP_9; sh_c = 1'b0; ng_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
    end else if (en) begin
      va <= in_vld; vb <= va; vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= x_c; ka <= k_c; sha <= sh_c; nga <= ng_c; sa <= s_in; sda <= side_in;
      prod <= (XW+KW)'(xa) * (XW+KW)'(ka);
      shb <= sha; ngb <= nga; sb <= sa; sdb <= sda;
    end
  end

  // quotient, flip for the upper piece, clamp to 1.0
  logic [XW-1:0] qt;
  logic [31:0]   r32;
  logic [SA-1:0] r_c;
  always_comb begin
    qt  = shb ? XW'(prod >> fgsm_pkg::SHIFT_29) : XW'(prod >> fgsm_pkg::SHIFT_10);
    r32 = ngb ? 32'(fgsm_pkg::SAT_ONE) - 32'(qt) : 32'(qt);
    r_c = (r32 > 32'(fgsm_pkg::SAT_ONE)) ? fgsm_pkg::SAT_ONE : SA'(r32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn <= r_c; s_out <= sb; side_out <= sdb;
    end
  end

  assign out_vld = vc;

endmodule

[hw/rtl/fgsm_checker.sv]
module fgsm_checker #(
  parameter int CHANNEL_BITS = 12
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [CHANNEL_BITS-1:0] out_red,
  input logic [CHANNEL_BITS-1:0] out_green,
  input logic [CHANNEL_BITS-1:0] out_blue
);

  // input valid is always driven out of reset
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(in_valid))
    else $error("input valid unknown");

  // input backs up only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // a waiting result holds its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red)
      && $stable(out_green) && $stable(out_blue)))
    else $error("stalled output transaction changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind filmic_gamma_saturation_map_top fgsm_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
);
